// ===== rtl/core/mbrtu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrtu_pkg
// shared types, constants and helpers for the modbus rtu motor frame encoder
// ----------------------------------------------------------------------------
package mbrtu_pkg;

   localparam int FRAME_BYTES = 15;
   localparam int FRAME_W     = FRAME_BYTES * 8;
   localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
   localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

   localparam logic [15:0] REG_SPEED_LEFT   = 16'h2088;
   localparam logic [15:0] REG_SPEED_RIGHT  = 16'h2089;
   localparam logic [15:0] REG_TORQUE_LEFT  = 16'h2090;
   localparam logic [15:0] REG_TORQUE_RIGHT = 16'h2091;
   localparam logic [15:0] REG_POS_LEFT     = 16'h208A;
   localparam logic [15:0] REG_POS_RIGHT    = 16'h208C;
   localparam logic [15:0] REG_CONTROL      = 16'h200E;

   localparam logic [7:0] START_BOTH  = 8'h10;
   localparam logic [7:0] START_LEFT  = 8'h11;
   localparam logic [7:0] START_RIGHT = 8'h12;

   typedef enum logic [2:0] {
      ACT_SPEED_ONE   = 3'd0,
      ACT_SPEED_BOTH  = 3'd1,
      ACT_TORQUE_ONE  = 3'd2,
      ACT_TORQUE_BOTH = 3'd3,
      ACT_POS_ONE     = 3'd4,
      ACT_POS_BOTH    = 3'd5,
      ACT_GENERIC     = 3'd6,
      ACT_NONE        = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DATA   = 2'd1,
      ST_CRC_LO = 2'd2,
      ST_CRC_HI = 2'd3
   } state_type;

   typedef struct packed {
      logic [FRAME_W-1:0] bytes;
      logic [CNT_W-1:0]   count;
   } frame_type;

   // one byte through the crc, bit at a time
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic frame_type single_frame(input logic [7:0] slave,
                                              input logic [15:0] reg_a,
                                              input logic [15:0] data);
      frame_type f;
      f.bytes = {slave, FC_WRITE_SINGLE, reg_a, data, 72'd0};
      f.count = CNT_W'(6);
      return f;
   endfunction

   function automatic frame_type multi2_frame(input logic [7:0] slave,
                                              input logic [15:0] reg_a,
                                              input logic [31:0] data);
      frame_type f;
      f.bytes = {slave, FC_WRITE_MULTI, reg_a, 16'h0002, 8'h04, data, 32'd0};
      f.count = CNT_W'(11);
      return f;
   endfunction

   function automatic frame_type multi4_frame(input logic [7:0] slave,
                                              input logic [31:0] data);
      frame_type f;
      f.bytes = {slave, FC_WRITE_MULTI, REG_POS_LEFT, 16'h0004, 8'h08, data, data};
      f.count = CNT_W'(15);
      return f;
   endfunction

endpackage

// ===== rtl/core/modbus_rtu_motor_frame_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_motor_frame_encoder
// turns one motor command into the modbus rtu byte sequence that carries it
//
// usage: raise start with the req_ fields while busy is low; the command is
// taken at that edge and busy rises. the bytes then come out one per cycle on
// rsp_out_byte, each marked by rsp_valid, which is held high while busy, with rsp_last on
// the final byte. the receiver cannot stall the output.
// the first byte is on the ports in the cycle after start is taken.
// busy stays high until the last byte of the command is out. a command has
// 8 bytes for single-wheel speed, torque and generic writes, 13 for both-wheel
// speed and torque, 21 for single-wheel position and 25 for both-wheel
// position. the rate is one byte per cycle, set by the byte-wide crc unit
// that every data byte passes through. busy falls after the last byte and
// the next command is taken at the end of the cycle in which busy is low.
// action code 7 is taken and produces nothing.
// csr_slave_address is written on csr_valid, always ready; write it only
// while busy is low. reset sets the slave address to 1 and goes idle.
// ----------------------------------------------------------------------------
module modbus_rtu_motor_frame_encoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_action,
   input  logic                req_wheel,
   input  logic signed [31:0]  req_value,
   input  logic [15:0]         req_reg_addr,
   output logic                rsp_valid,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_slave_address
);

   mbrtu_pkg::state_type                 state_ff, state_in;
   logic [mbrtu_pkg::FRAME_W-1:0]        frame_ff, frame_in;
   logic [mbrtu_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [15:0]                          crc_ff, crc_in;
   logic                                 second_ff, second_in;
   logic [7:0]                           code_ff, code_in;
   logic [7:0]                           slave_ff;
   logic [15:0]                          crc_step;
   logic                                 accept;
   mbrtu_pkg::action_type                act;
   mbrtu_pkg::frame_type                 load;
   mbrtu_pkg::frame_type                 start_frame;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign act       = mbrtu_pkg::action_type'(req_action);

   // shared crc unit, fed by the byte leaving the frame register
   assign crc_step = mbrtu_pkg::crc16_byte(crc_ff, frame_ff[mbrtu_pkg::FRAME_W-1 -: 8]);

   assign start_frame = mbrtu_pkg::single_frame(slave_ff, mbrtu_pkg::REG_CONTROL,
                                                {8'h00, code_ff});

   // frame built from the incoming command
   always_comb begin
      load = mbrtu_pkg::single_frame(slave_ff, req_reg_addr, req_value[15:0]);
      case (act)
         mbrtu_pkg::ACT_SPEED_ONE: begin
            load = mbrtu_pkg::single_frame(slave_ff,
               req_wheel ? mbrtu_pkg::REG_SPEED_RIGHT : mbrtu_pkg::REG_SPEED_LEFT,
               req_value[15:0]);
         end
         mbrtu_pkg::ACT_TORQUE_ONE: begin
            load = mbrtu_pkg::single_frame(slave_ff,
               req_wheel ? mbrtu_pkg::REG_TORQUE_RIGHT : mbrtu_pkg::REG_TORQUE_LEFT,
               req_value[15:0]);
         end
         mbrtu_pkg::ACT_SPEED_BOTH: begin
            load = mbrtu_pkg::multi2_frame(slave_ff, mbrtu_pkg::REG_SPEED_LEFT,
               {req_value[15:0], req_value[15:0]});
         end
         mbrtu_pkg::ACT_TORQUE_BOTH: begin
            load = mbrtu_pkg::multi2_frame(slave_ff, mbrtu_pkg::REG_TORQUE_LEFT,
               {req_value[15:0], req_value[15:0]});
         end
         mbrtu_pkg::ACT_POS_ONE: begin
            load = mbrtu_pkg::multi2_frame(slave_ff,
               req_wheel ? mbrtu_pkg::REG_POS_RIGHT : mbrtu_pkg::REG_POS_LEFT,
               req_value);
         end
         mbrtu_pkg::ACT_POS_BOTH: begin
            load = mbrtu_pkg::multi4_frame(slave_ff, req_value);
         end
         default: begin
            load = mbrtu_pkg::single_frame(slave_ff, req_reg_addr, req_value[15:0]);
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mbrtu_pkg::ST_IDLE: begin
            if (accept && act != mbrtu_pkg::ACT_NONE) begin
               state_in = mbrtu_pkg::ST_DATA;
            end
         end
         mbrtu_pkg::ST_DATA: begin
            if (cnt_ff == mbrtu_pkg::CNT_W'(1)) begin
               state_in = mbrtu_pkg::ST_CRC_LO;
            end
         end
         mbrtu_pkg::ST_CRC_LO: begin
            state_in = mbrtu_pkg::ST_CRC_HI;
         end
         mbrtu_pkg::ST_CRC_HI: begin
            state_in = second_ff ? mbrtu_pkg::ST_DATA : mbrtu_pkg::ST_IDLE;
         end
         default: begin
            state_in = mbrtu_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath
   always_comb begin
      frame_in  = frame_ff;
      cnt_in    = cnt_ff;
      crc_in    = crc_ff;
      second_in = second_ff;
      code_in   = code_ff;
      case (state_ff)
         mbrtu_pkg::ST_IDLE: begin
            if (accept) begin
               frame_in  = load.bytes;
               cnt_in    = load.count;
               crc_in    = mbrtu_pkg::CRC_INIT;
               second_in = (act == mbrtu_pkg::ACT_POS_ONE) ||
                           (act == mbrtu_pkg::ACT_POS_BOTH);
               if (act == mbrtu_pkg::ACT_POS_BOTH) begin
                  code_in = mbrtu_pkg::START_BOTH;
               end else begin
                  code_in = req_wheel ? mbrtu_pkg::START_RIGHT : mbrtu_pkg::START_LEFT;
               end
            end
         end
         mbrtu_pkg::ST_DATA: begin
            frame_in = {frame_ff[mbrtu_pkg::FRAME_W-9:0], 8'h00};
            cnt_in   = cnt_ff - mbrtu_pkg::CNT_W'(1);
            crc_in   = crc_step;
         end
         mbrtu_pkg::ST_CRC_HI: begin
            if (second_ff) begin
               frame_in  = start_frame.bytes;
               cnt_in    = start_frame.count;
               crc_in    = mbrtu_pkg::CRC_INIT;
               second_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      busy      = (state_ff != mbrtu_pkg::ST_IDLE);
      rsp_valid = busy;
      rsp_last  = (state_ff == mbrtu_pkg::ST_CRC_HI) && !second_ff;
      case (state_ff)
         mbrtu_pkg::ST_DATA:   rsp_out_byte = frame_ff[mbrtu_pkg::FRAME_W-1 -: 8];
         mbrtu_pkg::ST_CRC_LO: rsp_out_byte = crc_ff[7:0];
         mbrtu_pkg::ST_CRC_HI: rsp_out_byte = crc_ff[15:8];
         default:              rsp_out_byte = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mbrtu_pkg::ST_IDLE;
         second_ff <= 1'b0;
         cnt_ff    <= '0;
         slave_ff  <= 8'h01;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
         cnt_ff    <= cnt_in;
         if (csr_valid && csr_ready) begin
            slave_ff <= csr_slave_address;
         end
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      crc_ff   <= crc_in;
      code_ff  <= code_in;
   end

   a_crc_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == mbrtu_pkg::ST_CRC_LO |=> state_ff == mbrtu_pkg::ST_CRC_HI)
      else $error("crc high byte does not follow crc low byte");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !busy)
      else $error("still busy after last byte");

   a_first_byte: assert property (@(posedge clock) disable iff (reset)
      accept && act != mbrtu_pkg::ACT_NONE |=> rsp_valid && !rsp_last)
      else $error("no first byte after command taken");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == mbrtu_pkg::ST_DATA |-> cnt_ff != '0)
      else $error("data phase with empty byte count");

endmodule

// ===== tb/modbus_rtu_motor_frame_encoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_motor_frame_encoder_tb
// drives motor commands into the frame encoder and checks every output byte
// against a predicted byte stream. each frame's crc-16 is worked out here.
// several slave addresses are used. a directed set covers every action, both
// wheels and the value and register extremes. random commands follow, with
// random idle bursts on the command side in all but the last run.
// ----------------------------------------------------------------------------
module modbus_rtu_motor_frame_encoder_tb;

   class frame_scoreboard;
      logic [7:0]  slave_addr;
      logic [8:0]  expected_bytes[$];   // {last, byte}
      int unsigned errors;

      function new();
         slave_addr = 8'd1;
         errors     = 0;
      endfunction

      function void set_address(logic [7:0] a);
         slave_addr = a;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      // frame bytes are left-justified in bits, first byte on top
      local function void emit_frame(logic [119:0] bits, int unsigned nbytes);
         logic [15:0] c;
         logic [7:0]  d;
         c = mbrtu_pkg::CRC_INIT;
         for (int k = 0; k < nbytes; k++) begin
            d = bits[119 - 8*k -: 8];
            expected_bytes.push_back({1'b0, d});
            c = c ^ {8'h00, d};
            for (int b = 0; b < 8; b++) begin
               c = c[0] ? ((c >> 1) ^ mbrtu_pkg::CRC_POLY) : (c >> 1);
            end
         end
         expected_bytes.push_back({1'b0, c[7:0]});
         expected_bytes.push_back({1'b0, c[15:8]});
      endfunction

      local function void single_write(logic [15:0] reg_a, logic [15:0] data);
         emit_frame({slave_addr, mbrtu_pkg::FC_WRITE_SINGLE, reg_a, data, 72'd0}, 6);
      endfunction

      function void note_command(logic [2:0] act, logic wheel, logic [31:0] value,
                                 logic [15:0] reg_addr);
         logic [15:0] v16;
         logic [8:0]  tail;
         int          first;
         v16   = value[15:0];
         first = expected_bytes.size();
         case (mbrtu_pkg::action_type'(act))
            mbrtu_pkg::ACT_SPEED_ONE: begin
               single_write(wheel ? mbrtu_pkg::REG_SPEED_RIGHT : mbrtu_pkg::REG_SPEED_LEFT,
                            v16);
            end
            mbrtu_pkg::ACT_TORQUE_ONE: begin
               single_write(wheel ? mbrtu_pkg::REG_TORQUE_RIGHT : mbrtu_pkg::REG_TORQUE_LEFT,
                            v16);
            end
            mbrtu_pkg::ACT_SPEED_BOTH: begin
               emit_frame({slave_addr, mbrtu_pkg::FC_WRITE_MULTI, mbrtu_pkg::REG_SPEED_LEFT,
                           16'd2, 8'd4, v16, v16, 32'd0}, 11);
            end
            mbrtu_pkg::ACT_TORQUE_BOTH: begin
               emit_frame({slave_addr, mbrtu_pkg::FC_WRITE_MULTI, mbrtu_pkg::REG_TORQUE_LEFT,
                           16'd2, 8'd4, v16, v16, 32'd0}, 11);
            end
            mbrtu_pkg::ACT_POS_ONE: begin
               emit_frame({slave_addr, mbrtu_pkg::FC_WRITE_MULTI,
                           wheel ? mbrtu_pkg::REG_POS_RIGHT : mbrtu_pkg::REG_POS_LEFT,
                           16'd2, 8'd4, value, 32'd0}, 11);
               single_write(mbrtu_pkg::REG_CONTROL,
                            {8'h00, wheel ? mbrtu_pkg::START_RIGHT : mbrtu_pkg::START_LEFT});
            end
            mbrtu_pkg::ACT_POS_BOTH: begin
               emit_frame({slave_addr, mbrtu_pkg::FC_WRITE_MULTI, mbrtu_pkg::REG_POS_LEFT,
                           16'd4, 8'd8, value, value}, 15);
               single_write(mbrtu_pkg::REG_CONTROL, {8'h00, mbrtu_pkg::START_BOTH});
            end
            mbrtu_pkg::ACT_GENERIC: begin
               single_write(reg_addr, v16);
            end
            default: begin
            end
         endcase
         if (expected_bytes.size() > first) begin
            tail    = expected_bytes.pop_back();
            tail[8] = 1'b1;
            expected_bytes.push_back(tail);
         end
      endfunction

      function void check_byte(logic [7:0] b, logic last);
         logic [8:0] e;
         if (expected_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                     $time, b, last);
            return;
         end
         e = expected_bytes.pop_front();
         if (e[7:0] !== b) begin
            errors++;
            $display("%0t: out_byte expected %02h actual %02h", $time, e[7:0], b);
         end
         if (e[8] !== last) begin
            errors++;
            $display("%0t: last expected %0b actual %0b", $time, e[8], last);
         end
      endfunction
   endclass

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               start             = 1'b0;
   logic               busy;
   logic [2:0]         req_action        = 3'd0;
   logic               req_wheel         = 1'b0;
   logic signed [31:0] req_value         = 32'sd0;
   logic [15:0]        req_reg_addr      = 16'd0;
   logic               rsp_valid;
   logic [7:0]         rsp_out_byte;
   logic               rsp_last;
   logic               csr_valid         = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_slave_address = 8'd0;

   frame_scoreboard board;

   modbus_rtu_motor_frame_encoder dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_wheel         (req_wheel),
      .req_value         (req_value),
      .req_reg_addr      (req_reg_addr),
      .rsp_valid         (rsp_valid),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_slave_address (csr_slave_address)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // transaction monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            board.set_address(csr_slave_address);
         end
         if (start && !busy) begin
            board.note_command(req_action, req_wheel, req_value, req_reg_addr);
         end
         if (rsp_valid) begin
            board.check_byte(rsp_out_byte, rsp_last);
         end
      end
   end

   task automatic send_command(input mbrtu_pkg::action_type act, input logic wheel,
                               input logic [31:0] value, input logic [15:0] reg_addr);
      start        <= 1'b1;
      req_action   <= act;
      req_wheel    <= wheel;
      req_value    <= value;
      req_reg_addr <= reg_addr;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   task automatic idle_gap(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (board.pending() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_address(input logic [7:0] a);
      csr_valid         <= 1'b1;
      csr_slave_address <= a;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] random_value();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 5))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return {{16{r[15]}}, r[15:0]};
         3:       return {16'h0000, r[15:0]};
         default: return r;
      endcase
   endfunction

   task automatic run_random(input int unsigned count, input bit with_gaps);
      mbrtu_pkg::action_type act;
      int unsigned done;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 15) == 0) begin
            act = mbrtu_pkg::ACT_NONE;
         end else begin
            act = mbrtu_pkg::action_type'($urandom_range(0, 6));
            done++;
         end
         send_command(act, 1'($urandom_range(0, 1)), random_value(),
                      16'($urandom_range(0, 65535)));
         if (with_gaps && $urandom_range(0, 3) == 0) begin
            idle_gap($urandom_range(1, 16));
         end
      end
      start <= 1'b0;
   endtask

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed commands at the reset slave address
      send_command(mbrtu_pkg::ACT_SPEED_ONE,   1'b0, 32'h0000_0000, 16'h0000);
      send_command(mbrtu_pkg::ACT_SPEED_ONE,   1'b1, 32'hFFFF_FFFF, 16'hFFFF);
      send_command(mbrtu_pkg::ACT_SPEED_BOTH,  1'b0, 32'h0000_7FFF, 16'h0000);
      send_command(mbrtu_pkg::ACT_SPEED_BOTH,  1'b1, 32'hFFFF_8000, 16'hFFFF);
      send_command(mbrtu_pkg::ACT_TORQUE_ONE,  1'b0, 32'h1234_5678, 16'h0000);
      send_command(mbrtu_pkg::ACT_TORQUE_ONE,  1'b1, 32'h8000_0000, 16'hFFFF);
      send_command(mbrtu_pkg::ACT_TORQUE_BOTH, 1'b0, 32'hFFFF_FFFF, 16'h0000);
      send_command(mbrtu_pkg::ACT_TORQUE_BOTH, 1'b1, 32'h0000_0000, 16'hFFFF);
      send_command(mbrtu_pkg::ACT_POS_ONE,     1'b0, 32'h7FFF_FFFF, 16'h0000);
      send_command(mbrtu_pkg::ACT_POS_ONE,     1'b1, 32'h8000_0000, 16'hFFFF);
      send_command(mbrtu_pkg::ACT_POS_BOTH,    1'b0, 32'hFFFF_FFFF, 16'h0000);
      send_command(mbrtu_pkg::ACT_POS_BOTH,    1'b1, 32'h0000_0000, 16'hFFFF);
      send_command(mbrtu_pkg::ACT_GENERIC,     1'b0, 32'h0000_0000, 16'h0000);
      send_command(mbrtu_pkg::ACT_GENERIC,     1'b1, 32'hFFFF_FFFF, 16'hFFFF);
      send_command(mbrtu_pkg::ACT_GENERIC,     1'b1, 32'h0000_A55A, 16'h5AA5);
      send_command(mbrtu_pkg::ACT_NONE,        1'b1, 32'hFFFF_FFFF, 16'hFFFF);
      send_command(mbrtu_pkg::ACT_NONE,        1'b0, 32'h0000_0000, 16'h0000);
      send_command(mbrtu_pkg::ACT_SPEED_ONE,   1'b0, 32'hA5A5_5A5A, 16'h1234);
      send_command(mbrtu_pkg::ACT_GENERIC,     1'b0, 32'h0001_0011, mbrtu_pkg::REG_CONTROL);
      send_command(mbrtu_pkg::ACT_POS_ONE,     1'b1, 32'h0123_4567, 16'h0000);
      drain();

      write_address(8'd247);
      run_random(30, 1'b1);
      drain();

      write_address(8'd0);
      run_random(30, 1'b1);
      drain();

      write_address(8'($urandom_range(0, 247)));
      run_random(25, 1'b1);
      run_random(20, 1'b0);
      drain();

      if (board.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== modbus_rtu_motor_frame_encoder.f =====
rtl/core/mbrtu_pkg.sv
rtl/core/modbus_rtu_motor_frame_encoder.sv
tb/modbus_rtu_motor_frame_encoder_tb.sv
